>>> design/u16u8_pkg.sv
// shared types and constants for the utf-16 to utf-8 encoder
package u16u8_pkg;

   localparam int unsigned UNIT_WIDTH  = 16;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned HELD_WIDTH  = 10;
   localparam int unsigned FIFO_DEPTH  = 4;

   localparam logic [UNIT_WIDTH-1:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [UNIT_WIDTH-1:0] SURR_LOW_BASE  = 16'hDC00;
   localparam logic [UNIT_WIDTH-1:0] SURR_END       = 16'hE000;
   localparam logic [UNIT_WIDTH-1:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [UNIT_WIDTH-1:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [CP_WIDTH-1:0]   SUPP_OFFSET    = 21'h10000;

   localparam logic [BYTE_WIDTH-1:0] LEAD_TWO   = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_THREE = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_FOUR  = 8'hF0;
   localparam logic [BYTE_WIDTH-1:0] CONT_MARK  = 8'h80;

   // byte count of one queued job, minus one
   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } len_code_type;

   // one job for the byte serializer
   typedef struct packed {
      len_code_type          len;
      logic [CP_WIDTH-1:0]   cp;
      logic                  term;
      logic                  bad;
   } job_type;

endpackage

>>> design/u16u8_front.sv
// front end: accepts code units, tracks surrogate state, queues byte jobs
module u16u8_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [u16u8_pkg::UNIT_WIDTH-1:0]      unit,
   input  logic                                  q_full,
   output logic                                  q_push,
   output u16u8_pkg::job_type                    q_job
);
   import u16u8_pkg::*;

   logic [HELD_WIDTH-1:0] held_ff, held_in;
   logic                  pend_ff, pend_in;
   logic                  skip_ff, skip_in;
   logic                  accept;
   logic                  is_high, is_low, is_zero;
   logic                  has_job;
   job_type               job;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign is_zero    = (unit == '0);
   assign is_high    = (unit >= SURR_HIGH_BASE) && (unit < SURR_LOW_BASE);
   assign is_low     = (unit >= SURR_LOW_BASE) && (unit < SURR_END);

   always_comb begin
      held_in  = held_ff;
      pend_in  = pend_ff;
      skip_in  = skip_ff;
      has_job  = 1'b0;
      job.len  = LEN_ONE;
      job.cp   = '0;
      job.term = 1'b0;
      job.bad  = 1'b0;
      if (skip_ff) begin
         // drop everything up to the terminator
         if (is_zero) begin
            skip_in = 1'b0;
         end
      end else if (pend_ff) begin
         has_job = 1'b1;
         pend_in = 1'b0;
         held_in = '0;
         if (is_low) begin
            job.len = LEN_FOUR;
            job.cp  = {1'b0, held_ff, unit[HELD_WIDTH-1:0]} + SUPP_OFFSET;
         end else begin
            // broken pair
            job.term = 1'b1;
            job.bad  = 1'b1;
            skip_in  = !is_zero;
         end
      end else if (is_zero) begin
         has_job  = 1'b1;
         job.term = 1'b1;
      end else if (unit < ONE_BYTE_LIMIT) begin
         has_job = 1'b1;
         job.cp  = CP_WIDTH'(unit);
      end else if (unit < TWO_BYTE_LIMIT) begin
         has_job = 1'b1;
         job.len = LEN_TWO;
         job.cp  = CP_WIDTH'(unit);
      end else if (is_high) begin
         held_in = unit[HELD_WIDTH-1:0];
         pend_in = 1'b1;
      end else if (is_low) begin
         has_job  = 1'b1;
         job.term = 1'b1;
         job.bad  = 1'b1;
         skip_in  = 1'b1;
      end else begin
         has_job = 1'b1;
         job.len = LEN_THREE;
         job.cp  = CP_WIDTH'(unit);
      end
   end

   assign q_push = accept && has_job;
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pend_ff <= 1'b0;
         skip_ff <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         pend_ff <= pend_in;
         skip_ff <= skip_in;
      end
   end

   // a held high surrogate and error skipping never coexist
   a_pend_skip_excl: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && skip_ff))
      else $error("high surrogate held while skipping");

   // nothing is queued while skipping
   a_no_job_skip: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> !q_push)
      else $error("job queued while skipping");

   // any unit that follows a held high surrogate clears it
   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && pend_ff) |=> !pend_ff)
      else $error("held surrogate survived its follower");

endmodule

>>> design/u16u8_fifo.sv
// short job queue between front end and byte serializer
module u16u8_fifo #(
   parameter int unsigned Depth = u16u8_pkg::FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u16u8_pkg::job_type    push_job,
   input  logic                  pop,
   output u16u8_pkg::job_type    head_job,
   output logic                  full,
   output logic                  empty
);
   import u16u8_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   job_type               slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ff, wr_in;
   logic [PtrWidth-1:0]   rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full     = (cnt_ff == CntWidth'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntWidth'(Depth))
      else $error("queue count beyond depth");

endmodule

>>> design/u16u8_back.sv
// back end: turns queued jobs into utf-8 bytes, one per cycle unless the output stalls
module u16u8_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  u16u8_pkg::job_type                    head_job,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [u16u8_pkg::BYTE_WIDTH-1:0]      out_byte,
   output logic                                  run_last,
   output logic                                  string_end,
   output logic                                  bad_surrogate
);
   import u16u8_pkg::*;

   logic [1:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff, byte_in;
   logic                  last_ff, end_ff, bad_ff;
   logic                  advance, load, at_last;
   logic [1:0]            from_end;

   assign advance  = !valid_ff || rsp_tready;
   assign load     = advance && !q_empty;
   assign at_last  = (idx_ff == head_job.len);
   assign q_pop    = load && at_last;
   assign from_end = head_job.len - idx_ff;

   always_comb begin
      byte_in = '0;
      if (idx_ff == '0) begin
         unique case (head_job.len)
            LEN_ONE:   byte_in = head_job.cp[7:0];
            LEN_TWO:   byte_in = LEAD_TWO | BYTE_WIDTH'(head_job.cp[10:6]);
            LEN_THREE: byte_in = LEAD_THREE | BYTE_WIDTH'(head_job.cp[15:12]);
            LEN_FOUR:  byte_in = LEAD_FOUR | BYTE_WIDTH'(head_job.cp[20:18]);
            default:   byte_in = '0;
         endcase
      end else begin
         case (from_end)
            2'd0:    byte_in = CONT_MARK | BYTE_WIDTH'(head_job.cp[5:0]);
            2'd1:    byte_in = CONT_MARK | BYTE_WIDTH'(head_job.cp[11:6]);
            2'd2:    byte_in = CONT_MARK | BYTE_WIDTH'(head_job.cp[17:12]);
            default: byte_in = '0;
         endcase
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= at_last;
         end_ff  <= head_job.term;
         bad_ff  <= head_job.bad;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign out_byte      = byte_ff;
   assign run_last      = last_ff;
   assign string_end    = end_ff;
   assign bad_surrogate = bad_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (idx_ff <= head_job.len))
      else $error("byte index past job length");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> (last_ff && byte_ff == '0))
      else $error("terminator not a lone zero byte");

   a_bad_ends: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && bad_ff) |-> end_ff)
      else $error("error marker without string end");

endmodule

>>> design/utf16_to_utf8_encoder.sv
// top level of the utf-16 to utf-8 encoder
// One 16-bit UTF-16 code unit enters per req word and comes out as zero to
// four UTF-8 bytes, one rsp word per byte, at one byte per clock while
// rsp_tready is high. A unit is taken in the cycle it arrives as long as the
// job queue (FifoDepth entries) has room, so the input side runs at one unit
// per cycle until the byte side falls behind; the sustained rate is then set
// by the byte serializer, which emits one byte for ASCII, two for units below
// 0x800, three for other BMP units and four for a surrogate pair (the high
// half itself produces nothing). A zero unit ends the string and yields a
// zero byte with tuser string_end set. An unpaired surrogate yields one zero
// byte with string_end and bad_surrogate set, after which units are dropped
// without output up to and including the next zero unit. rsp_tlast marks the
// final byte produced by each input unit. The output sits behind a register,
// so the block keeps accepting while a byte waits to be taken.
module utf16_to_utf8_encoder #(
   parameter int unsigned FifoDepth = u16u8_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [15:0] code_unit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: [7:0] out_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // rsp_tlast: run_last, final byte of one input unit
   output logic        rsp_tlast,
   // rsp_tuser: [0] string_end, [1] bad_surrogate
   output logic [1:0]  rsp_tuser
);
   import u16u8_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    q_push, q_pop, q_full, q_empty;
   logic    string_end, bad_surrogate;

   // classify units and keep surrogate / skip state
   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .unit       (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // decouples unit intake from byte output
   u16u8_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // serialize each job into bytes behind an output register
   u16u8_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_byte      (rsp_tdata),
      .run_last      (rsp_tlast),
      .string_end    (string_end),
      .bad_surrogate (bad_surrogate)
   );

   assign rsp_tuser = {bad_surrogate, string_end};

endmodule
